@@ sv/bba_pkg.sv @@
// ---------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers of the buddy block allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MAX_ORDER = 11;
  localparam int NUM_ORDERS = MAX_ORDER + 1;
  localparam int ADDR_W = MAX_ORDER;
  localparam int ORDER_W = 4;
  localparam int REQ_W = 12;
  localparam int SLOT_W = MAX_ORDER + 1;
  localparam int WORD_W = 32;
  localparam int BIT_W = 5;
  localparam int WORD_AW = SLOT_W - BIT_W;
  localparam int NUM_WORDS = 1 << WORD_AW;
  localparam int CNT_W = MAX_ORDER + 1;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_PROBE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  // One read port and one write port of the free map, both word wide.
  typedef struct packed {
    logic                 re;
    logic [WORD_AW-1:0]   raddr;
    logic                 we;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_W-1:0]    wdata;
  } ram_req_t;

  // Bit position of block (k, addr) in the free map; k must not exceed MAX_ORDER.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ORDER_W-1:0] k,
                                                input logic [ADDR_W-1:0] addr);
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] offs;
    base = SLOT_W'(1) << (ORDER_W'(MAX_ORDER) - k);
    offs = SLOT_W'(addr >> k);
    return base + offs;
  endfunction

endpackage

`default_nettype wire

@@ sv/bba_free_map.sv @@
// ---------------------------------------------------------------------------
// bba_free_map
// Word-wide free bitmap memory with per-word valid bits for reset clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_free_map (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bba_pkg::ram_req_t            req_i,
  output logic [bba_pkg::WORD_W-1:0]        rdata_o
);
  import bba_pkg::*;

  logic [WORD_W-1:0]  mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]  raw_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      raw_q <= mem[req_i.raddr];
    end
  end

  // A word that was never written since reset reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? raw_q : '0;

endmodule

`default_nettype wire

@@ sv/buddy_block_allocator.sv @@
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over 2^MAX_ORDER units with a word-organized free bitmap.
// ---------------------------------------------------------------------------
// Steps: a rejected request goes straight to the response; probe and insert read
// the block's bitmap word, then answer or write it; release checks the block, reads
// its buddy at each order, takes a free buddy out and climbs, then marks the merged
// block free; allocate scans the bitmap words of the found order, clears the hit
// and marks each split-off upper half free. One transaction is in work at a time;
// the next is accepted in the cycle after the result is loaded. Reset clears the
// per-word valid bits, free counters and control at once, so the map reads as all clear.
`default_nettype none

module buddy_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] opcode, [12:2] block_address, [16:13] block_order,
  // [28:17] request_units, [31:29] zero
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [12:2] granted_address, [16:13] granted_order,
  // [17] probe_free, [23:18] zero
  output logic [23:0]      m_axis_tdata_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_CHK, S_MRD, S_MCHK, S_FCHK,
    S_SRD, S_SCHK, S_PRD, S_PWR, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic [1:0]         op_q, op_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ORDER_W-1:0] k_q, k_d;
  logic [REQ_W-1:0]   req_q, req_d;
  logic [ORDER_W-1:0] r_q, r_d;
  logic [ORDER_W-1:0] j_q, j_d;
  logic [WORD_AW-1:0] ptr_q, ptr_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [WORD_AW-1:0] wa_q, wa_d;
  logic [CNT_W-1:0]   cnt_q [NUM_ORDERS];
  logic [CNT_W-1:0]   cnt_d [NUM_ORDERS];
  logic [1:0]         stat_q, stat_d;
  logic [ADDR_W-1:0]  gaddr_q, gaddr_d;
  logic [ORDER_W-1:0] gord_q, gord_d;
  logic               pfree_q, pfree_d;
  logic               ovld_q, ovld_d;
  logic [23:0]        odata_q, odata_d;

  ram_req_t           ram;
  logic [WORD_W-1:0]  rdata;
  logic               cur_bit;

  bba_free_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram),
    .rdata_o (rdata)
  );

  assign cur_bit = rdata[bit_q];

  // Decode helpers.
  logic               blk_bad;
  logic [15:0]        align_mask;
  logic [ORDER_W-1:0] r_calc;
  logic               r_over;
  logic [ORDER_W-1:0] j_calc;
  logic               j_found;
  logic [SLOT_W:0]    lo_slot;
  logic [SLOT_W:0]    hi_slot;
  logic [WORD_W-1:0]  hit;
  logic [BIT_W-1:0]   hit_pos;
  logic [SLOT_W-1:0]  hit_slot;
  logic [SLOT_W-1:0]  tgt_slot;
  logic [ADDR_W-1:0]  half_addr;
  logic [ORDER_W-1:0] jm1;

  always_comb begin
    align_mask = (16'(1) << k_q) - 16'(1);
    blk_bad = (k_q > ORDER_W'(MAX_ORDER)) || ((16'(addr_q) & align_mask) != 16'(0));

    // Rounded-up order of the request; a request of 4095 at most rounds to 12.
    r_calc = '0;
    r_over = 1'b1;
    for (int i = REQ_W; i >= 0; i--) begin
      if ((13'(1) << i) >= 13'(req_q)) begin
        r_calc = ORDER_W'(i);
      end
    end
    r_over = r_calc > ORDER_W'(MAX_ORDER);

    j_calc = '0;
    j_found = 1'b0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ((ORDER_W'(i) >= r_calc) && (cnt_q[i] != '0)) begin
        j_calc = ORDER_W'(i);
        j_found = 1'b1;
      end
    end

    // Slots of order j form the range [2^(MAX_ORDER-j), 2^(MAX_ORDER-j+1)).
    lo_slot = (SLOT_W+1)'(1) << (ORDER_W'(MAX_ORDER) - j_q);
    hi_slot = lo_slot << 1;
    for (int i = 0; i < WORD_W; i++) begin
      hit[i] = rdata[i] && ({1'b0, ptr_q, BIT_W'(i)} >= lo_slot) &&
               ({1'b0, ptr_q, BIT_W'(i)} < hi_slot);
    end
    hit_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_pos = BIT_W'(i);
      end
    end
    hit_slot = {ptr_q, hit_pos};
    jm1 = j_q - ORDER_W'(1);
    half_addr = gaddr_q + (ADDR_W'(1) << jm1);
    tgt_slot = '0;
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    addr_d = addr_q;
    k_d = k_q;
    req_d = req_q;
    r_d = r_q;
    j_d = j_q;
    ptr_d = ptr_q;
    bit_d = bit_q;
    wa_d = wa_q;
    cnt_d = cnt_q;
    stat_d = stat_q;
    gaddr_d = gaddr_q;
    gord_d = gord_q;
    pfree_d = pfree_q;
    ovld_d = ovld_q;
    odata_d = odata_q;
    ram = '0;

    if (ovld_q && m_axis_tready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d = s_axis_tdata_i[1:0];
          addr_d = s_axis_tdata_i[12:2];
          k_d = s_axis_tdata_i[16:13];
          req_d = s_axis_tdata_i[28:17];
          stat_d = ST_OK;
          gaddr_d = '0;
          gord_d = '0;
          pfree_d = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (op_q == OP_ALLOC) begin
          if (req_q == '0) begin
            stat_d = ST_BAD;
            state_d = S_RESP;
          end else if (r_over || !j_found) begin
            stat_d = ST_NO_SPACE;
            state_d = S_RESP;
          end else begin
            r_d = r_calc;
            j_d = j_calc;
            ptr_d = WORD_AW'((SLOT_W'(1) << (ORDER_W'(MAX_ORDER) - j_calc)) >> BIT_W);
            state_d = S_SRD;
          end
        end else if (blk_bad) begin
          stat_d = ST_BAD;
          state_d = S_RESP;
        end else begin
          ram.re = 1'b1;
          {ram.raddr, bit_d} = slot_of(k_q, addr_q);
          wa_d = ram.raddr;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (op_q == OP_PROBE) begin
          pfree_d = cur_bit;
          state_d = S_RESP;
        end else if (cur_bit) begin
          stat_d = ST_DOUBLE;
          state_d = S_RESP;
        end else if (op_q == OP_INSERT) begin
          ram.we = 1'b1;
          ram.waddr = wa_q;
          ram.wdata = rdata | (WORD_W'(1) << bit_q);
          cnt_d[k_q] = cnt_q[k_q] + CNT_W'(1);
          state_d = S_RESP;
        end else begin
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        ram.re = 1'b1;
        if (k_q < ORDER_W'(MAX_ORDER)) begin
          {ram.raddr, bit_d} = slot_of(k_q, addr_q ^ (ADDR_W'(1) << k_q));
          state_d = S_MCHK;
        end else begin
          {ram.raddr, bit_d} = slot_of(k_q, addr_q);
          state_d = S_FCHK;
        end
        wa_d = ram.raddr;
      end
      S_MCHK: begin
        if (cur_bit) begin
          // Buddy is free: take it out and climb one order.
          ram.we = 1'b1;
          ram.waddr = wa_q;
          ram.wdata = rdata & ~(WORD_W'(1) << bit_q);
          cnt_d[k_q] = cnt_q[k_q] - CNT_W'(1);
          addr_d = addr_q & ~(ADDR_W'(1) << k_q);
          k_d = k_q + ORDER_W'(1);
          state_d = S_MRD;
        end else begin
          ram.re = 1'b1;
          {ram.raddr, bit_d} = slot_of(k_q, addr_q);
          wa_d = ram.raddr;
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!cur_bit) begin
          ram.we = 1'b1;
          ram.waddr = wa_q;
          ram.wdata = rdata | (WORD_W'(1) << bit_q);
          cnt_d[k_q] = cnt_q[k_q] + CNT_W'(1);
        end
        state_d = S_RESP;
      end
      S_SRD: begin
        ram.re = 1'b1;
        ram.raddr = ptr_q;
        wa_d = ptr_q;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (hit != '0) begin
          ram.we = 1'b1;
          ram.waddr = wa_q;
          ram.wdata = rdata & ~(WORD_W'(1) << hit_pos);
          cnt_d[j_q] = cnt_q[j_q] - CNT_W'(1);
          gaddr_d = ADDR_W'(16'(hit_slot - SLOT_W'(lo_slot)) << j_q);
          state_d = S_PRD;
        end else begin
          ptr_d = ptr_q + WORD_AW'(1);
          state_d = S_SRD;
        end
      end
      S_PRD: begin
        if (j_q > r_q) begin
          // Upper half at the next lower order becomes free.
          ram.re = 1'b1;
          {ram.raddr, bit_d} = slot_of(jm1, half_addr);
          wa_d = ram.raddr;
          j_d = jm1;
          state_d = S_PWR;
        end else begin
          gord_d = r_q;
          state_d = S_RESP;
        end
      end
      S_PWR: begin
        // An upper half that is already marked free stays as it is.
        if (!cur_bit) begin
          ram.we = 1'b1;
          ram.waddr = wa_q;
          ram.wdata = rdata | (WORD_W'(1) << bit_q);
          cnt_d[j_q] = cnt_q[j_q] + CNT_W'(1);
        end
        state_d = S_PRD;
      end
      S_RESP: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d = 1'b1;
          odata_d = {6'b0, pfree_q, gord_q, gaddr_q, stat_q};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (tgt_slot != '0) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ovld_q <= ovld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    addr_q <= addr_d;
    k_q <= k_d;
    req_q <= req_d;
    r_q <= r_d;
    j_q <= j_d;
    ptr_q <= ptr_d;
    bit_q <= bit_d;
    wa_q <= wa_d;
    stat_q <= stat_d;
    gaddr_q <= gaddr_d;
    gord_q <= gord_d;
    pfree_q <= pfree_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o = odata_q;

  // The sequencer never reads a word in the same cycle it writes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram.we && ram.re && (ram.waddr == ram.raddr)))
    else $error("bitmap read and write overlap on one word");

  // Only one block of the top order exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[MAX_ORDER] <= CNT_W'(1))
    else $error("top order free count above one");

  // A new result appears only from the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_RESP))
    else $error("result raised outside response state");

endmodule

`default_nettype wire
